[rtl/core/wdcc_pkg.sv]
`timescale 1ns / 1ps

package wdcc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_MM_PER_PIXEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_ENTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_HOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_ZONE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 3'd4;

    localparam int ANGLE_W = 18;
    localparam int ERR_W = 19;
    localparam int MAG_W = 15;
    localparam int ATAN_IW = 5;
    localparam int ATAN_DEPTH = 24;

    localparam int PI_Q13 = 25736;
    localparam int TWO_PI_Q13 = 51472;
    localparam int BAND_70 = 10008;
    localparam int BAND_40 = 5719;
    localparam int BAND_25 = 3574;
    localparam int BAND_5 = 715;
    localparam logic [15:0] RATIO_K_HALF = 16'd58671;
    localparam logic [15:0] RATIO_K_SMALL = 16'd9153;

    localparam logic [8:0] SPEED_TURN_WIDE = 9'd300;
    localparam logic [8:0] SPEED_TURN = 9'd200;
    localparam logic [8:0] SPEED_CURVE_SHARP = 9'd100;
    localparam logic [8:0] SPEED_CURVE = 9'd350;
    localparam logic [8:0] SPEED_CURVE_SLOW = 9'd250;
    localparam logic [8:0] SPEED_FORWARD = 9'd400;
    localparam logic [8:0] SPEED_FORWARD_SLOW = 9'd300;
    localparam logic [8:0] SPEED_FINAL_APPROACH = 9'd150;

    localparam logic [12:0] ATAN_TABLE [ATAN_DEPTH] = '{
        13'd6434, 13'd3798, 13'd2007, 13'd1019, 13'd511, 13'd256, 13'd128, 13'd64,
        13'd32, 13'd16, 13'd8, 13'd4, 13'd2, 13'd1, 13'd0, 13'd0,
        13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0
    };

    typedef enum logic [2:0] {
        CMD_STOP = 3'd0,
        CMD_TURN_RIGHT = 3'd1,
        CMD_TURN_LEFT = 3'd2,
        CMD_FORWARD_RIGHT = 3'd3,
        CMD_FORWARD_LEFT = 3'd4,
        CMD_FORWARD = 3'd5
    } wdcc_cmd_t;

    typedef struct packed {
        logic regulate_enable;
        logic restart_target;
        logic [15:0] robot_x;
        logic [15:0] robot_y;
        logic signed [15:0] robot_heading;
        logic [9:0] target_x;
        logic [9:0] target_y;
        logic target_is_last;
    } wdcc_in_t;

    typedef struct packed {
        wdcc_cmd_t drive_command;
        logic [8:0] drive_speed;
        logic [14:0] turn_ratio;
        logic target_reached;
    } wdcc_out_t;

endpackage

[rtl/core/wdcc_channels.sv]
`timescale 1ns / 1ps

interface wdcc_in_if;
    import wdcc_pkg::*;
    logic valid;
    logic ready;
    wdcc_in_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface wdcc_out_if;
    import wdcc_pkg::*;
    logic valid;
    logic ready;
    wdcc_out_t data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface wdcc_cfg_if;
    import wdcc_pkg::*;
    logic valid;
    logic ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] wdata;
    modport source(output valid, output index, output wdata, input ready);
    modport sink(input valid, input index, input wdata, output ready);
endinterface

[rtl/core/waypoint_drive_command_controller.sv]
`timescale 1ns / 1ps
// Waypoint drive command controller.
// in_ch carries one word per control tick: enable, restart, robot pose and the
// next waypoint. A word with regulate_enable low gives no result; only its
// restart_target acts. An enabled word gives exactly one word on out_ch.
// cfg_ch writes the five setup registers; it is always ready and should be
// used only while the block is idle. Indexes beyond the list are ignored.
// A disabled word is handled in the idle state. An enabled word runs through
// a bit-serial shift-and-add multiplier (one multiplier bit per cycle, ending
// early when the multiplier has fewer significant bits) for the squared
// distance and limits, then an iterative CORDIC, then a serial multiply for
// the curve ratio. A near target stops after the limit check and gives its
// result without the later steps. One word is worked on at a time; in_ch is
// ready again as soon as the result sits in the output register, so a stalled
// receiver only blocks once the next result is also finished and waiting.
// Reset clears the reached flag, the settle counter and the output valid, and
// loads the default setup registers.

module waypoint_drive_command_controller #(
    parameter int POS_FRAC_BITS = 6,
    parameter int CORDIC_ITERATIONS = 16
) (
    input logic clk,
    input logic rst_n,
    wdcc_in_if.sink in_ch,
    wdcc_out_if.source out_ch,
    wdcc_cfg_if.sink cfg_ch
);
    import wdcc_pkg::*;

    localparam int TW = 10 + POS_FRAC_BITS;
    localparam int MW = (TW > 16) ? TW : 16;
    localparam int DW = MW + 1;
    localparam int D2W = 2 * MW + 1;
    localparam int BW = MW;
    localparam int PW = D2W + BW;
    localparam int HALF = (1 << POS_FRAC_BITS) >> 1;
    localparam logic signed [ERR_W-1:0] ERR_PI = ERR_W'(PI_Q13);
    localparam logic signed [ERR_W-1:0] ERR_TWO_PI = ERR_W'(TWO_PI_Q13);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQM,
        ST_SCALE,
        ST_LIMN,
        ST_LIMS,
        ST_ATAN,
        ST_WRAP,
        ST_RATIO,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic mul_start_reg;
    logic cor_start_reg;
    logic out_valid_reg;
    wdcc_out_t out_data_reg;
    logic reached_reg;
    logic [3:0] settle_cnt_reg;
    logic [7:0] mm_reg;
    logic [11:0] enter_reg;
    logic [11:0] hold_reg;
    logic [11:0] slow_zone_reg;
    logic [3:0] settle_ticks_reg;

    logic signed [DW-1:0] dx_reg;
    logic signed [DW-1:0] dy_reg;
    logic signed [15:0] heading_reg;
    logic last_reg;
    logic [D2W-1:0] d2_reg;
    logic [15:0] m2_reg;
    logic [PW-1:0] scaled_reg;
    logic slow_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [15:0] k_reg;
    wdcc_cmd_t res_cmd_reg;
    logic [8:0] res_speed_reg;
    logic [14:0] res_ratio_reg;

    logic signed [DW-1:0] tx;
    logic signed [DW-1:0] ty;
    logic [MW-1:0] adx;
    logic [MW-1:0] ady;
    logic [D2W-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic mul_done;
    logic [PW-1:0] mul_p;
    logic [PW-1:0] lim_sq;
    logic near;
    logic cor_done;
    logic signed [ANGLE_W-1:0] cor_angle;
    logic signed [ERR_W-1:0] err_abs;
    logic [MAG_W-1:0] mag;
    logic err_pos;
    logic [31:0] ratio_sum;

    assign tx = (DW'(in_ch.data.target_x) << POS_FRAC_BITS) + DW'(HALF);
    assign ty = (DW'(in_ch.data.target_y) << POS_FRAC_BITS) + DW'(HALF);
    assign adx = MW'((dx_reg < 0) ? -dx_reg : dx_reg);
    assign ady = MW'((dy_reg < 0) ? -dy_reg : dy_reg);
    assign lim_sq = mul_p << (2 * POS_FRAC_BITS);
    assign near = reached_reg ? (scaled_reg <= lim_sq) : (scaled_reg < lim_sq);
    assign err_abs = (err_reg < 0) ? -err_reg : err_reg;
    assign mag = err_abs[MAG_W-1:0];
    assign err_pos = (err_reg > 0);
    assign ratio_sum = mul_p[31:0] + 32'd32768;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQX:
            begin
                mul_a = D2W'(adx);
                mul_b = adx;
            end
            ST_SQY:
            begin
                mul_a = D2W'(ady);
                mul_b = ady;
            end
            ST_SQM:
            begin
                mul_a = D2W'(mm_reg);
                mul_b = BW'(mm_reg);
            end
            ST_SCALE:
            begin
                mul_a = d2_reg;
                mul_b = BW'(m2_reg);
            end
            ST_LIMN:
            begin
                mul_a = D2W'(reached_reg ? hold_reg : enter_reg);
                mul_b = BW'(reached_reg ? hold_reg : enter_reg);
            end
            ST_LIMS:
            begin
                mul_a = D2W'(slow_zone_reg);
                mul_b = BW'(slow_zone_reg);
            end
            ST_RATIO:
            begin
                mul_a = D2W'(mag_reg);
                mul_b = BW'(k_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    wdcc_sermul #(
        .AW(D2W),
        .BW(BW)
    ) u_mul (
        .clk(clk),
        .rst_n(rst_n),
        .start(mul_start_reg),
        .a(mul_a),
        .b(mul_b),
        .done(mul_done),
        .product(mul_p)
    );

    wdcc_cordic #(
        .DW(DW),
        .ITERATIONS(CORDIC_ITERATIONS)
    ) u_cordic (
        .clk(clk),
        .rst_n(rst_n),
        .start(cor_start_reg),
        .dx(dx_reg),
        .dy(dy_reg),
        .done(cor_done),
        .angle(cor_angle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mul_start_reg <= 1'b0;
            cor_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            reached_reg <= 1'b0;
            settle_cnt_reg <= '0;
            mm_reg <= 8'd10;
            enter_reg <= 12'd70;
            hold_reg <= 12'd200;
            slow_zone_reg <= 12'd250;
            settle_ticks_reg <= 4'd10;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            cor_start_reg <= 1'b0;

            if (cfg_ch.valid)
            begin
                unique case (cfg_ch.index)
                    REG_MM_PER_PIXEL: mm_reg <= cfg_ch.wdata[7:0];
                    REG_NEAR_ENTER: enter_reg <= cfg_ch.wdata;
                    REG_NEAR_HOLD: hold_reg <= cfg_ch.wdata;
                    REG_SLOW_ZONE: slow_zone_reg <= cfg_ch.wdata;
                    REG_SETTLE_TICKS: settle_ticks_reg <= cfg_ch.wdata[3:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        if (in_ch.data.restart_target)
                        begin
                            reached_reg <= 1'b0;
                            settle_cnt_reg <= '0;
                        end
                        dx_reg <= tx - DW'(in_ch.data.robot_x);
                        dy_reg <= ty - DW'(in_ch.data.robot_y);
                        heading_reg <= in_ch.data.robot_heading;
                        last_reg <= in_ch.data.target_is_last;
                        if (in_ch.data.regulate_enable)
                        begin
                            state_reg <= ST_SQX;
                            mul_start_reg <= 1'b1;
                        end
                    end
                end
                ST_SQX:
                begin
                    if (mul_done)
                    begin
                        d2_reg <= mul_p[D2W-1:0];
                        state_reg <= ST_SQY;
                        mul_start_reg <= 1'b1;
                    end
                end
                ST_SQY:
                begin
                    if (mul_done)
                    begin
                        d2_reg <= d2_reg + mul_p[D2W-1:0];
                        state_reg <= ST_SQM;
                        mul_start_reg <= 1'b1;
                    end
                end
                ST_SQM:
                begin
                    if (mul_done)
                    begin
                        m2_reg <= mul_p[15:0];
                        state_reg <= ST_SCALE;
                        mul_start_reg <= 1'b1;
                    end
                end
                ST_SCALE:
                begin
                    if (mul_done)
                    begin
                        scaled_reg <= mul_p;
                        state_reg <= ST_LIMN;
                        mul_start_reg <= 1'b1;
                    end
                end
                ST_LIMN:
                begin
                    if (mul_done)
                    begin
                        if (near)
                        begin
                            if (!reached_reg)
                            begin
                                if (settle_cnt_reg > settle_ticks_reg)
                                begin
                                    reached_reg <= last_reg;
                                    settle_cnt_reg <= '0;
                                end
                                else if (settle_cnt_reg != 4'hF)
                                begin
                                    settle_cnt_reg <= settle_cnt_reg + 4'd1;
                                end
                            end
                            else
                            begin
                                reached_reg <= last_reg;
                            end
                            res_cmd_reg <= CMD_STOP;
                            res_speed_reg <= '0;
                            res_ratio_reg <= '0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            reached_reg <= 1'b0;
                            settle_cnt_reg <= '0;
                            state_reg <= ST_LIMS;
                            mul_start_reg <= 1'b1;
                        end
                    end
                end
                ST_LIMS:
                begin
                    if (mul_done)
                    begin
                        slow_reg <= (scaled_reg <= lim_sq);
                        state_reg <= ST_ATAN;
                        cor_start_reg <= 1'b1;
                    end
                end
                ST_ATAN:
                begin
                    if (cor_done)
                    begin
                        err_reg <= ERR_W'(cor_angle) - ERR_W'(heading_reg);
                        state_reg <= ST_WRAP;
                    end
                end
                ST_WRAP:
                begin
                    priority if (err_reg > ERR_PI)
                    begin
                        err_reg <= err_reg - ERR_TWO_PI;
                    end
                    else if (err_reg < -ERR_PI)
                    begin
                        err_reg <= err_reg + ERR_TWO_PI;
                    end
                    else
                    begin
                        mag_reg <= mag;
                        res_ratio_reg <= '0;
                        priority if (mag > MAG_W'(BAND_70))
                        begin
                            res_speed_reg <= SPEED_TURN_WIDE;
                            res_cmd_reg <= err_pos ? CMD_TURN_RIGHT : CMD_TURN_LEFT;
                            state_reg <= ST_DONE;
                        end
                        else if (mag > MAG_W'(BAND_40))
                        begin
                            res_speed_reg <= SPEED_TURN;
                            res_cmd_reg <= err_pos ? CMD_TURN_RIGHT : CMD_TURN_LEFT;
                            state_reg <= ST_DONE;
                        end
                        else if (mag > MAG_W'(BAND_25))
                        begin
                            res_speed_reg <= SPEED_CURVE_SHARP;
                            res_cmd_reg <= err_pos ? CMD_FORWARD_RIGHT : CMD_FORWARD_LEFT;
                            k_reg <= RATIO_K_HALF;
                            state_reg <= ST_RATIO;
                            mul_start_reg <= 1'b1;
                        end
                        else if (mag > MAG_W'(BAND_5))
                        begin
                            res_speed_reg <= slow_reg
                                ? (last_reg ? SPEED_FINAL_APPROACH : SPEED_CURVE_SLOW)
                                : SPEED_CURVE;
                            res_cmd_reg <= err_pos ? CMD_FORWARD_RIGHT : CMD_FORWARD_LEFT;
                            k_reg <= RATIO_K_SMALL;
                            state_reg <= ST_RATIO;
                            mul_start_reg <= 1'b1;
                        end
                        else
                        begin
                            res_speed_reg <= slow_reg
                                ? (last_reg ? SPEED_FINAL_APPROACH : SPEED_FORWARD_SLOW)
                                : SPEED_FORWARD;
                            res_cmd_reg <= CMD_FORWARD;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_RATIO:
                begin
                    if (mul_done)
                    begin
                        res_ratio_reg <= 15'(ratio_sum[31:16]) + 15'd256;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_data_reg.drive_command <= res_cmd_reg;
                        out_data_reg.drive_speed <= res_speed_reg;
                        out_data_reg.turn_ratio <= res_ratio_reg;
                        out_data_reg.target_reached <= reached_reg;
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_data_reg;

    // A moving command always comes with the reached flag low.
    a_move_not_reached: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.drive_command != CMD_STOP
        |-> !out_ch.data.target_reached)
        else $error("moving command with target reached");

    // Only curve commands carry a ratio.
    a_ratio_only_curve: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.data.drive_command == CMD_STOP
            || out_ch.data.drive_command == CMD_TURN_RIGHT
            || out_ch.data.drive_command == CMD_TURN_LEFT
            || out_ch.data.drive_command == CMD_FORWARD)
        |-> out_ch.data.turn_ratio == '0)
        else $error("ratio on a non-curve command");

    // A restart clears the settle counter for the tick that follows.
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_ch.data.restart_target
        |=> settle_cnt_reg == '0 && !reached_reg)
        else $error("restart did not clear the settle state");

endmodule

[rtl/core/wdcc_sermul.sv]
`timescale 1ns / 1ps

module wdcc_sermul #(
    parameter int AW = 33,
    parameter int BW = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [AW-1:0] a,
    input  logic [BW-1:0] b,
    output logic done,
    output logic [AW+BW-1:0] product
);
    localparam int PW = AW + BW;

    logic run_reg;
    logic done_reg;
    logic [PW-1:0] mcand_reg;
    logic [BW-1:0] mplier_reg;
    logic [PW-1:0] acc_reg;

    // One multiplier bit is retired per cycle; the run ends once no set bits remain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                mcand_reg <= PW'(a);
                mplier_reg <= b;
                acc_reg <= '0;
            end
            else if (run_reg)
            begin
                if (mplier_reg == '0)
                begin
                    run_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end
            end
        end
    end

    assign done = done_reg;
    assign product = acc_reg;

endmodule

[rtl/core/wdcc_cordic.sv]
`timescale 1ns / 1ps

module wdcc_cordic #(
    parameter int DW = 17,
    parameter int ITERATIONS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic signed [DW-1:0] dx,
    input  logic signed [DW-1:0] dy,
    output logic done,
    output logic signed [wdcc_pkg::ANGLE_W-1:0] angle
);
    import wdcc_pkg::*;

    localparam int XW = DW + 18;
    localparam int IW = $clog2(ITERATIONS + 1);

    logic run_reg;
    logic done_reg;
    logic [IW-1:0] iter_reg;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [ANGLE_W-1:0] z_reg;
    logic signed [XW-1:0] x_init;
    logic signed [XW-1:0] y_init;
    logic signed [XW-1:0] x_shift;
    logic signed [XW-1:0] y_shift;
    logic signed [ANGLE_W-1:0] step_angle;

    assign x_init = XW'(dx) <<< 16;
    assign y_init = XW'(dy) <<< 16;
    assign x_shift = x_reg >>> iter_reg;
    assign y_shift = y_reg >>> iter_reg;
    assign step_angle = ANGLE_W'(ATAN_TABLE[ATAN_IW'(iter_reg)]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                if (dx == '0 && dy == '0)
                begin
                    // A zero vector has bearing zero.
                    iter_reg <= IW'(ITERATIONS);
                    z_reg <= '0;
                end
                else if (dx < 0)
                begin
                    iter_reg <= '0;
                    x_reg <= -x_init;
                    y_reg <= -y_init;
                    z_reg <= (dy >= 0) ? ANGLE_W'(PI_Q13) : -ANGLE_W'(PI_Q13);
                end
                else
                begin
                    iter_reg <= '0;
                    x_reg <= x_init;
                    y_reg <= y_init;
                    z_reg <= '0;
                end
            end
            else if (run_reg)
            begin
                if (iter_reg == IW'(ITERATIONS))
                begin
                    run_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    if (y_reg >= 0)
                    begin
                        x_reg <= x_reg + y_shift;
                        y_reg <= y_reg - x_shift;
                        z_reg <= z_reg + step_angle;
                    end
                    else
                    begin
                        x_reg <= x_reg - y_shift;
                        y_reg <= y_reg + x_shift;
                        z_reg <= z_reg - step_angle;
                    end
                    iter_reg <= iter_reg + 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign angle = z_reg;

endmodule

[bench/waypoint_drive_command_controller_test.sv]
`timescale 1ns / 1ps

module waypoint_drive_command_controller_test;
    import wdcc_pkg::*;

    typedef struct {
        logic [2:0] cmd;
        logic [8:0] speed;
        logic [14:0] ratio;
        logic reached;
    } drive_word_t;

    class drive_scoreboard;
        int unsigned mm_px = 10;
        int unsigned enter_mm = 70;
        int unsigned hold_mm = 200;
        int unsigned slow_mm = 250;
        int unsigned settle_lim = 10;
        bit reached = 0;
        int unsigned settle_cnt = 0;
        drive_word_t pending[$];
        int errors = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_MM_PER_PIXEL: mm_px = v[7:0];
                REG_NEAR_ENTER: enter_mm = v;
                REG_NEAR_HOLD: hold_mm = v;
                REG_SLOW_ZONE: slow_mm = v;
                REG_SETTLE_TICKS: settle_lim = v[3:0];
                default: ;
            endcase
        endfunction

        function longint shr(longint v, int s);
            return v >>> s;
        endfunction

        function longint bearing(longint dy, longint dx);
            longint x;
            longint y;
            longint z;
            longint xs;
            longint ys;
            int tbl[14];
            tbl = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
            x = dx * 65536;
            y = dy * 65536;
            z = 0;
            if (dx == 0 && dy == 0)
            begin
                return 0;
            end
            if (x < 0)
            begin
                z = (y >= 0) ? PI_Q13 : -PI_Q13;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < 16; i++)
            begin
                xs = shr(x, i);
                ys = shr(y, i);
                if (y >= 0)
                begin
                    x += ys;
                    y -= xs;
                    z += (i < 14) ? tbl[i] : 0;
                end
                else
                begin
                    x -= ys;
                    y += xs;
                    z -= (i < 14) ? tbl[i] : 0;
                end
            end
            return z;
        endfunction

        function void note_input(wdcc_in_t w);
            longint dx;
            longint dy;
            longint err;
            longint mag;
            longint unsigned scaled;
            bit near;
            bit slow;
            drive_word_t r;
            if (w.restart_target)
            begin
                reached = 0;
                settle_cnt = 0;
            end
            if (!w.regulate_enable)
            begin
                return;
            end
            r.cmd = CMD_STOP;
            r.speed = 0;
            r.ratio = 0;
            dx = longint'({w.target_x, 6'd32}) - longint'(w.robot_x);
            dy = longint'({w.target_y, 6'd32}) - longint'(w.robot_y);
            scaled = (dx * dx + dy * dy) * mm_px * mm_px;
            if (reached)
                near = scaled <= ((longint'(hold_mm) * hold_mm) << 12);
            else
                near = scaled < ((longint'(enter_mm) * enter_mm) << 12);
            if (near)
            begin
                if (!reached)
                begin
                    if (settle_cnt > settle_lim)
                    begin
                        reached = w.target_is_last;
                        settle_cnt = 0;
                    end
                    else if (settle_cnt < 15)
                    begin
                        settle_cnt++;
                    end
                end
                else
                begin
                    reached = w.target_is_last;
                end
            end
            else
            begin
                slow = scaled <= ((longint'(slow_mm) * slow_mm) << 12);
                reached = 0;
                settle_cnt = 0;
                err = bearing(dy, dx) - longint'(w.robot_heading);
                while (err > PI_Q13) err -= TWO_PI_Q13;
                while (err < -PI_Q13) err += TWO_PI_Q13;
                mag = (err < 0) ? -err : err;
                if (mag > BAND_70 || mag > BAND_40)
                begin
                    r.speed = (mag > BAND_70) ? SPEED_TURN_WIDE : SPEED_TURN;
                    r.cmd = (err > 0) ? CMD_TURN_RIGHT : CMD_TURN_LEFT;
                end
                else if (mag > BAND_5)
                begin
                    r.cmd = (err > 0) ? CMD_FORWARD_RIGHT : CMD_FORWARD_LEFT;
                    if (mag > BAND_25)
                    begin
                        r.speed = SPEED_CURVE_SHARP;
                        r.ratio = 256 + ((mag * RATIO_K_HALF + 32768) >> 16);
                    end
                    else
                    begin
                        r.speed = slow ? (w.target_is_last ? SPEED_FINAL_APPROACH
                            : SPEED_CURVE_SLOW) : SPEED_CURVE;
                        r.ratio = 256 + ((mag * RATIO_K_SMALL + 32768) >> 16);
                    end
                end
                else
                begin
                    r.cmd = CMD_FORWARD;
                    r.speed = slow ? (w.target_is_last ? SPEED_FINAL_APPROACH
                        : SPEED_FORWARD_SLOW) : SPEED_FORWARD;
                end
            end
            r.reached = reached;
            pending.push_back(r);
        endfunction

        function void check_result(wdcc_out_t got);
            drive_word_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: cmd %0d speed %0d ratio %0d reached %0d",
                        got.drive_command, got.drive_speed, got.turn_ratio,
                        got.target_reached);
                return;
            end
            e = pending.pop_front();
            if (got.drive_command !== e.cmd || got.drive_speed !== e.speed
                || got.turn_ratio !== e.ratio || got.target_reached !== e.reached)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        e.cmd, e.speed, e.ratio, e.reached, got.drive_command,
                        got.drive_speed, got.turn_ratio, got.target_reached);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int send_idle_pct;
    int recv_stall_pct;
    drive_scoreboard board;

    wdcc_in_if in_ch();
    wdcc_out_if out_ch();
    wdcc_cfg_if cfg_ch();

    waypoint_drive_command_controller u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_ch(cfg_ch.sink)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                board.note_input(in_ch.data);
            if (out_ch.valid && out_ch.ready)
                board.check_result(out_ch.data);
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(wdcc_in_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        board.set_reg(idx, v);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic setup(int mm, int ent, int hld, int slw, int st);
        drain();
        write_reg(REG_MM_PER_PIXEL, mm);
        write_reg(REG_NEAR_ENTER, ent);
        write_reg(REG_NEAR_HOLD, hld);
        write_reg(REG_SLOW_ZONE, slw);
        write_reg(REG_SETTLE_TICKS, st);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic wdcc_in_t rand_word(bit close);
        wdcc_in_t w;
        w.regulate_enable = ($urandom_range(9) != 0);
        w.restart_target = ($urandom_range(15) == 0);
        w.target_x = $urandom;
        w.target_y = $urandom;
        w.target_is_last = $urandom;
        w.robot_heading = $urandom_range(51471) - 25736;
        if ($urandom_range(19) == 0)
            w.robot_heading = $urandom;
        if (close)
        begin
            w.robot_x = {w.target_x, 6'd0} + $urandom_range(80) - 8;
            w.robot_y = {w.target_y, 6'd0} + $urandom_range(80) - 8;
        end
        else
        begin
            w.robot_x = $urandom;
            w.robot_y = $urandom;
        end
        return w;
    endfunction

    function automatic wdcc_in_t make_word(bit en, bit rs, int rx, int ry, int hd,
        int tx, int ty, bit last);
        wdcc_in_t w;
        w.regulate_enable = en;
        w.restart_target = rs;
        w.robot_x = rx;
        w.robot_y = ry;
        w.robot_heading = hd;
        w.target_x = tx;
        w.target_y = ty;
        w.target_is_last = last;
        return w;
    endfunction

    task automatic random_phase(int n, int idle, int stall);
        int tx;
        int ty;
        bit last;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
            begin
                tx = $urandom;
                ty = $urandom;
                last = $urandom;
                for (int k = $urandom_range(18, 4); k > 0; k--)
                    send_word(make_word(1, 0, {tx[9:0], 6'd0} + $urandom_range(64),
                        {ty[9:0], 6'd0} + $urandom_range(64), $urandom_range(51471) - 25736,
                        tx, ty, last));
            end
            else
            begin
                send_word(rand_word($urandom_range(2) == 0));
            end
        end
    endtask

    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        board = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.wdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(make_word(1, 0, 32, 32, 0, 0, 0, 1));
        send_word(make_word(1, 0, 0, 0, 0, 1023, 1023, 0));
        send_word(make_word(1, 0, 65535, 65535, -25736, 0, 0, 1));
        send_word(make_word(1, 0, 65535, 0, 25735, 0, 1023, 0));
        send_word(make_word(1, 1, 0, 65535, 16'h8000, 1023, 0, 1));
        send_word(make_word(1, 0, 100, 1000, 16'h7fff, 500, 20, 0));
        send_word(make_word(1, 0, 6432, 3200, 6000, 100, 50, 1));
        send_word(make_word(1, 0, 6432, 3200, -4000, 100, 50, 0));
        send_word(make_word(0, 1, 0, 0, 0, 0, 0, 0));
        for (int k = 0; k < 14; k++)
            send_word(make_word(1, 0, 3232, 3232, 0, 50, 50, k[0] | (k > 12)));
        send_word(make_word(1, 0, 3232, 3232, 0, 55, 50, 1));

        random_phase(35, 0, 0);
        setup(255, 4095, 4095, 4095, 0);
        random_phase(30, 80, 0);
        setup(1, 0, 0, 0, 15);
        random_phase(30, 0, 80);
        setup(0, 1000, 10, 3000, 3);
        random_phase(15, 32, 32);
        setup(10, 70, 200, 250, 10);
        random_phase(35, 32, 32);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[waypoint_drive_command_controller.f]
rtl/core/wdcc_pkg.sv
rtl/core/wdcc_channels.sv
rtl/core/wdcc_sermul.sv
rtl/core/wdcc_cordic.sv
rtl/core/waypoint_drive_command_controller.sv
bench/waypoint_drive_command_controller_test.sv
